// ===== src/blrfp_pkg.sv =====
// ----------------------------------------------------------------------------
// blrfp_pkg
// Shared types and constants for the bond list range filter parser.
// ----------------------------------------------------------------------------
package blrfp_pkg;

    // Character codes that steer the parser.
    localparam logic [7:0] CHAR_TAB  = 8'd9;
    localparam logic [7:0] CHAR_NL   = 8'd10;
    localparam logic [7:0] CHAR_ZERO = 8'd48;
    localparam logic [7:0] CHAR_NINE = 8'd57;

    // Token accumulator width and its saturation value.
    localparam int unsigned TOKEN_W = 20;
    localparam logic [TOKEN_W-1:0] TOKEN_MAX = {TOKEN_W{1'b1}};

    // Result value width.
    localparam int unsigned VALUE_W = 24;

    // Configuration register indexes.
    localparam int unsigned CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTRE_LOW  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTRE_HIGH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_OUTER_LOW   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_OUTER_HIGH  = 2'd3;

    typedef enum logic [1:0] {
        KIND_BOND_ATOM  = 2'd0,
        KIND_LINE_END   = 2'd1,
        KIND_MAX_ATOMS  = 2'd2
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t        kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } entry_t;

endpackage

// ===== src/bond_list_range_filter_parser_core.sv =====
// ----------------------------------------------------------------------------
// bond_list_range_filter_parser_core
// Parses a tab and newline separated text of atom numbers, one byte per
// transaction, and emits the in-range bond atoms, line end offsets and the
// largest atom count per line.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata, s_tlast) carries one text
//   byte per transaction; s_tlast marks the last byte of the text. The master
//   channel (m_tvalid, m_tready, m_tdata, m_tuser, m_tlast) carries results:
//   the entry kind in m_tuser, its value in m_tdata, and m_tlast high on the
//   maximum count that follows the last byte.
//   The four range bounds are written through cfg_wr_en, cfg_addr and cfg_wdata;
//   the user must do so only while the block is idle; the block does not check it.
//   Each byte is parsed in the cycle it is accepted; its results are registered
//   into a four-entry result queue that drives the master side.
//   A byte gives at most two results, and the queue drains one result per
//   cycle while m_tready is high, so the block takes one byte per cycle while
//   results flow and m_tready stays high; a byte that gives two results needs
//   two transfers on the master side.
//   s_tready is high while the queue holds two results or fewer, so it does
//   not depend on m_tready. When the receiver stalls the queue fills and
//   input is held off; nothing is dropped.
//   Reset clears the parser state, the range bounds and the queue.
// ----------------------------------------------------------------------------
module bond_list_range_filter_parser_core
    import blrfp_pkg::*;
#(
    parameter int unsigned ATOM_ID_WIDTH = 16,
    parameter int unsigned OFFSET_WIDTH  = 24
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ATOM_ID_WIDTH-1:0] cfg_wdata,

    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,   // [7:0] char_code
    input  logic                     s_tlast,   // final_char

    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [VALUE_W-1:0]       m_tdata,   // [23:0] entry_value
    output logic [1:0]               m_tuser,   // [1:0] entry_kind
    output logic                     m_tlast    // last_entry
);

    localparam int unsigned CMP_W  = (ATOM_ID_WIDTH > TOKEN_W) ? ATOM_ID_WIDTH : TOKEN_W;
    localparam int unsigned SUM_W  =
        ((OFFSET_WIDTH > ATOM_ID_WIDTH) ? OFFSET_WIDTH : ATOM_ID_WIDTH) + 1;
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;

    localparam logic [ATOM_ID_WIDTH-1:0] ATOM_MAX   = {ATOM_ID_WIDTH{1'b1}};
    localparam logic [OFFSET_WIDTH-1:0]  OFFSET_MAX = {OFFSET_WIDTH{1'b1}};

    // Range bounds.
    logic [ATOM_ID_WIDTH-1:0] centre_low_reg, centre_high_reg;
    logic [ATOM_ID_WIDTH-1:0] outer_low_reg, outer_high_reg;

    // Parser state.
    logic [TOKEN_W-1:0]       token_reg, token_next;
    logic                     line_start_reg, line_start_next;
    logic                     line_counted_reg, line_counted_next;
    logic [ATOM_ID_WIDTH-1:0] line_atoms_reg, line_atoms_next;
    logic [ATOM_ID_WIDTH-1:0] max_atoms_reg, max_atoms_next;
    logic [OFFSET_WIDTH-1:0]  offset_reg, offset_next;

    // Result queue.
    entry_t              queue_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    logic                in_fire, out_fire;
    logic                is_digit;
    logic [3:0]          digit;
    logic [VALUE_W-1:0]  token_prod;
    logic [CMP_W-1:0]    token_cmp;
    logic                in_range;
    logic [SUM_W-1:0]    offset_sum;
    logic [VALUE_W+OFFSET_WIDTH-1:0]  offset_ext;
    logic [VALUE_W+ATOM_ID_WIDTH-1:0] max_ext;
    logic                line_valid;
    entry_t              line_entry, final_entry;
    entry_t              push0, push1;
    logic [1:0]          push_cnt;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign s_tready = (count_reg < QCNT_W'(3));

    assign is_digit   = (s_tdata >= CHAR_ZERO) && (s_tdata <= CHAR_NINE);
    assign digit      = 4'(s_tdata - CHAR_ZERO);
    assign token_prod = VALUE_W'(token_reg) * VALUE_W'(10) + VALUE_W'(digit);
    assign token_cmp  = CMP_W'(token_reg);
    assign in_range   =
        ((token_cmp >= CMP_W'(centre_low_reg)) && (token_cmp <= CMP_W'(centre_high_reg))) ||
        ((token_cmp >= CMP_W'(outer_low_reg))  && (token_cmp <= CMP_W'(outer_high_reg)));
    assign offset_sum = SUM_W'(offset_reg) + SUM_W'(line_atoms_reg);

    // Parser next state and the result of the current byte.
    always_comb
    begin
        token_next        = token_reg;
        line_start_next   = line_start_reg;
        line_counted_next = line_counted_reg;
        line_atoms_next   = line_atoms_reg;
        max_atoms_next    = max_atoms_reg;
        offset_next       = offset_reg;
        line_valid        = 1'b0;
        line_entry.kind   = KIND_BOND_ATOM;
        line_entry.value  = VALUE_W'(token_reg);
        line_entry.last   = 1'b0;

        if (is_digit)
        begin
            token_next = (token_prod > VALUE_W'(TOKEN_MAX)) ? TOKEN_MAX
                                                            : token_prod[TOKEN_W-1:0];
        end
        else if (s_tdata == CHAR_TAB)
        begin
            if (line_start_reg || line_counted_reg)
            begin
                if (in_range)
                begin
                    if (line_start_reg)
                    begin
                        line_start_next   = 1'b0;
                        line_counted_next = 1'b1;
                    end
                    else
                    begin
                        line_valid = 1'b1;
                        if (line_atoms_reg != ATOM_MAX)
                        begin
                            line_atoms_next = line_atoms_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    line_start_next = 1'b0;
                end
            end
            token_next = '0;
        end
        else if (s_tdata == CHAR_NL)
        begin
            if (line_atoms_reg > max_atoms_reg)
            begin
                max_atoms_next = line_atoms_reg;
            end
            if (line_counted_reg)
            begin
                offset_next = (offset_sum > SUM_W'(OFFSET_MAX)) ? OFFSET_MAX
                                                                : offset_sum[OFFSET_WIDTH-1:0];
                line_valid      = 1'b1;
                line_entry.kind = KIND_LINE_END;
            end
            line_atoms_next   = '0;
            line_counted_next = 1'b0;
            line_start_next   = 1'b1;
            token_next        = '0;
        end

        // Zero-extend or truncate to the result width.
        offset_ext = {{VALUE_W{1'b0}}, offset_next};
        max_ext    = {{VALUE_W{1'b0}}, max_atoms_next};
        if (line_entry.kind == KIND_LINE_END)
        begin
            line_entry.value = offset_ext[VALUE_W-1:0];
        end

        final_entry.kind  = KIND_MAX_ATOMS;
        final_entry.value = max_ext[VALUE_W-1:0];
        final_entry.last  = 1'b1;

        push0 = line_valid ? line_entry : final_entry;
        push1 = final_entry;
        push_cnt = 2'(line_valid) + 2'(s_tlast);
    end

    // Queue pointers.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (in_fire)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(push_cnt);
            count_next  = count_next + QCNT_W'(push_cnt);
        end
        if (out_fire)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
            count_next  = count_next - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_low_reg   <= '0;
            centre_high_reg  <= '0;
            outer_low_reg    <= '0;
            outer_high_reg   <= '0;
            token_reg        <= '0;
            line_start_reg   <= 1'b1;
            line_counted_reg <= 1'b0;
            line_atoms_reg   <= '0;
            max_atoms_reg    <= '0;
            offset_reg       <= '0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            count_reg        <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_CENTRE_LOW:  centre_low_reg  <= cfg_wdata;
                    REG_CENTRE_HIGH: centre_high_reg <= cfg_wdata;
                    REG_OUTER_LOW:   outer_low_reg   <= cfg_wdata;
                    REG_OUTER_HIGH:  outer_high_reg  <= cfg_wdata;
                    default:         ;
                endcase
            end
            if (in_fire)
            begin
                token_reg        <= token_next;
                line_start_reg   <= line_start_next;
                line_counted_reg <= line_counted_next;
                line_atoms_reg   <= line_atoms_next;
                max_atoms_reg    <= max_atoms_next;
                offset_reg       <= offset_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage; the second slot is only written when a byte gives two results.
    always_ff @(posedge clk)
    begin
        if (in_fire && (push_cnt != 2'd0))
        begin
            queue_reg[wr_ptr_reg] <= push0;
        end
        if (in_fire && (push_cnt == 2'd2))
        begin
            queue_reg[wr_ptr_reg + 1'b1] <= push1;
        end
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = queue_reg[rd_ptr_reg].value;
    assign m_tuser  = queue_reg[rd_ptr_reg].kind;
    assign m_tlast  = queue_reg[rd_ptr_reg].last;

endmodule
